@@ hw/rtl/ptc_pkg.sv @@
// shared types and constants for the pressure/temperature compensator
package ptc_pkg;

  typedef struct packed {
    logic        kind;
    logic [19:0] raw_value;
  } ptc_in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_by_zero;
  } ptc_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } ptc_op_req_t;

  localparam logic [1:0] REG_TEMP    = 2'd0;
  localparam logic [1:0] REG_PRESS_A = 2'd1;
  localparam logic [1:0] REG_PRESS_B = 2'd2;
  localparam logic [1:0] REG_PRESS_9 = 2'd3;

  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  localparam logic [63:0] T_FINE_OFFSET = 64'd128000;
  localparam logic [63:0] P_FULL_SCALE  = 64'd1048576;
  localparam logic [63:0] P_SCALE       = 64'd3125;
  localparam logic [31:0] T_SCALE       = 32'd5;
  localparam logic [31:0] T_ROUND       = 32'd128;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

@@ hw/rtl/ptc_mul.sv @@
// 64x64 multiplier, low 64 bits of product, one 32x32 partial product per cycle
module ptc_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptc_pkg::ptc_op_req_t req,
  output logic                 done,
  output logic [63:0]          product
);

  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [31:0] op_x, op_y;
  logic [63:0] pp;

  always_comb begin
    case (phase_r)
      2'd0: begin
        op_x = a_r[31:0];
        op_y = b_r[31:0];
      end
      2'd1: begin
        op_x = a_r[31:0];
        op_y = b_r[63:32];
      end
      default: begin
        op_x = a_r[63:32];
        op_y = b_r[31:0];
      end
    endcase
  end

  assign pp = {32'd0, op_x} * {32'd0, op_y};

  always_comb begin
    acc_nxt   = acc_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 2'd0;
    end else if (busy_r) begin
      if (phase_r == 2'd0) begin
        acc_nxt = pp;
      end else begin
        acc_nxt = acc_r + {pp[31:0], 32'd0};
      end
      phase_nxt = phase_r + 2'd1;
      if (phase_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
    acc_r <= acc_nxt;
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

@@ hw/rtl/ptc_div.sv @@
// 64-bit signed divider, radix 2, truncates toward zero
module ptc_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptc_pkg::ptc_op_req_t req,
  output logic                 done,
  output logic [63:0]          quotient
);

  logic [63:0] n_r, n_nxt, d_r, d_nxt;
  logic [64:0] rem_r, rem_nxt, rem_sh, rem_sub;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;

  assign rem_sh  = {rem_r[63:0], n_r[63]};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (req.start) begin
      n_nxt    = req.a[63] ? (64'd0 - req.a) : req.a;
      d_nxt    = req.b[63] ? (64'd0 - req.b) : req.b;
      neg_nxt  = req.a[63] ^ req.b[63];
      rem_nxt  = 65'd0;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits shift in where numerator bits leave
      if (!rem_sub[64]) begin
        rem_nxt = rem_sub;
        n_nxt   = {n_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        n_nxt   = {n_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (64'd0 - n_r) : n_r;

endmodule

@@ hw/rtl/pressure_temperature_compensator.sv @@
// top level: sequencer around a shared multiplier and divider
// temperature word: 4 multiplies from accept to result
// pressure word: 10 multiplies plus a divide
// one word at a time; the next word is taken once the result is in the output register
// zero divisor ends a pressure word before the divide with the flag set; synchronous reset
// clears coefficients, fine temperature and handshake state
module pressure_temperature_compensator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptc_pkg::ptc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptc_pkg::ptc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DWAIT = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        kind_r;
  logic [19:0] raw_r;
  logic [47:0] tc_r;
  logic [63:0] pa_r, pb_r;
  logic [15:0] p9_r;
  logic [31:0] ft_r, ft_nxt;
  logic [63:0] sq_r, sq_nxt, v2_r, v2_nxt, x_r, x_nxt, den_r, den_nxt;
  logic [63:0] q_r, q_nxt, s_r, s_nxt, t_r, t_nxt;
  logic [31:0] rt_r, rt_nxt, rp_r, rp_nxt;
  logic        dz_r, dz_nxt;
  logic        out_valid_r, out_valid_nxt;
  ptc_pkg::ptc_out_t out_data_r, out_data_nxt;

  ptc_pkg::ptc_op_req_t mul_req, div_req;
  logic        mul_done, div_done;
  logic [63:0] mp, dq;

  logic [31:0] raw32, ta32, tb32, mp_rnd;
  logic [63:0] v1p, num, qs, fin_sum;

  ptc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .done(mul_done), .product(mp));
  ptc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(dq));

  assign raw32  = {12'd0, raw_r};
  assign ta32   = (raw32 >> 3) - {15'd0, tc_r[15:0], 1'b0};
  assign tb32   = (raw32 >> 4) - {16'd0, tc_r[15:0]};
  assign mp_rnd = mp[31:0] + ptc_pkg::T_ROUND;
  assign v1p    = ptc_pkg::sx32(ft_r) - ptc_pkg::T_FINE_OFFSET;
  assign num    = ((ptc_pkg::P_FULL_SCALE - {44'd0, raw_r}) << 31) - v2_r;
  assign qs     = $signed(q_r) >>> 13;
  assign fin_sum = q_r + t_r + 64'($signed(mp) >>> 19);

  // multiplier operands for each step
  always_comb begin
    mul_req.start = (state_r == ST_ISSUE);
    mul_req.a     = 64'd0;
    mul_req.b     = 64'd0;
    if (kind_r == ptc_pkg::KIND_TEMP) begin
      case (step_r)
        4'd0: begin
          mul_req.a = ptc_pkg::sx32(ta32);
          mul_req.b = ptc_pkg::sx16(tc_r[31:16]);
        end
        4'd1: begin
          mul_req.a = ptc_pkg::sx32(tb32);
          mul_req.b = ptc_pkg::sx32(tb32);
        end
        4'd2: begin
          mul_req.a = s_r;
          mul_req.b = ptc_pkg::sx16(tc_r[47:32]);
        end
        default: begin
          mul_req.a = ptc_pkg::sx32(ft_r);
          mul_req.b = ptc_pkg::sx32(ptc_pkg::T_SCALE);
        end
      endcase
    end else begin
      case (step_r)
        4'd0: begin
          mul_req.a = v1p;
          mul_req.b = v1p;
        end
        4'd1: begin
          mul_req.a = sq_r;
          mul_req.b = ptc_pkg::sx16(pb_r[31:16]);
        end
        4'd2: begin
          mul_req.a = v1p;
          mul_req.b = ptc_pkg::sx16(pb_r[15:0]);
        end
        4'd3: begin
          mul_req.a = sq_r;
          mul_req.b = ptc_pkg::sx16(pa_r[47:32]);
        end
        4'd4: begin
          mul_req.a = v1p;
          mul_req.b = ptc_pkg::sx16(pa_r[31:16]);
        end
        4'd5: begin
          mul_req.a = (64'd1 << 47) + x_r;
          mul_req.b = {48'd0, pa_r[15:0]};
        end
        4'd6: begin
          mul_req.a = num;
          mul_req.b = ptc_pkg::P_SCALE;
        end
        4'd7: begin
          mul_req.a = ptc_pkg::sx16(p9_r);
          mul_req.b = qs;
        end
        4'd8: begin
          mul_req.a = t_r;
          mul_req.b = s_r;
        end
        default: begin
          mul_req.a = ptc_pkg::sx16(pb_r[63:48]);
          mul_req.b = q_r;
        end
      endcase
    end
  end

  always_comb begin
    div_req.start = (state_r == ST_DIV);
    div_req.a     = q_r;
    div_req.b     = den_r;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ft_nxt        = ft_r;
    sq_nxt        = sq_r;
    v2_nxt        = v2_r;
    x_nxt         = x_r;
    den_nxt       = den_r;
    q_nxt         = q_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    rt_nxt        = rt_r;
    rp_nxt        = rp_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ISSUE;
          step_nxt  = 4'd0;
          rt_nxt    = 32'd0;
          rp_nxt    = 32'd0;
          dz_nxt    = 1'b0;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          state_nxt = ST_ISSUE;
          step_nxt  = step_r + 4'd1;
          if (kind_r == ptc_pkg::KIND_TEMP) begin
            case (step_r)
              4'd0: x_nxt = ptc_pkg::sx32(32'($signed(mp[31:0]) >>> 11));
              4'd1: s_nxt = ptc_pkg::sx32(32'($signed(mp[31:0]) >>> 12));
              4'd2: ft_nxt = x_r[31:0] + 32'($signed(mp[31:0]) >>> 14);
              default: begin
                rt_nxt    = 32'($signed(mp_rnd) >>> 8);
                state_nxt = ST_OUT;
              end
            endcase
          end else begin
            case (step_r)
              4'd0: sq_nxt = mp;
              4'd1: v2_nxt = mp;
              4'd2: v2_nxt = v2_r + (mp << 17) + (ptc_pkg::sx16(pa_r[63:48]) << 35);
              4'd3: x_nxt = $signed(mp) >>> 8;
              4'd4: x_nxt = x_r + (mp << 12);
              4'd5: begin
                den_nxt = $signed(mp) >>> 33;
                if (($signed(mp) >>> 33) == 64'sd0) begin
                  dz_nxt    = 1'b1;
                  state_nxt = ST_OUT;
                end
              end
              4'd6: begin
                q_nxt     = mp;
                state_nxt = ST_DIV;
              end
              4'd7: begin
                t_nxt = mp;
                s_nxt = qs;
              end
              4'd8: t_nxt = $signed(mp) >>> 25;
              default: begin
                rp_nxt    = 32'(($signed(fin_sum) >>> 8)
                                + $signed(ptc_pkg::sx16(pb_r[47:32]) << 4));
                state_nxt = ST_OUT;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          q_nxt     = dq;
          step_nxt  = 4'd7;
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.result_kind       = kind_r;
          out_data_nxt.temperature_centi = rt_r;
          out_data_nxt.pressure_q24_8    = rp_r;
          out_data_nxt.divide_by_zero    = dz_r;
          state_nxt                      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
      ft_r        <= 32'd0;
      tc_r        <= 48'd0;
      pa_r        <= 64'd0;
      pb_r        <= 64'd0;
      p9_r        <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      ft_r        <= ft_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ptc_pkg::REG_TEMP:    tc_r <= cfg_data[47:0];
          ptc_pkg::REG_PRESS_A: pa_r <= cfg_data;
          ptc_pkg::REG_PRESS_B: pb_r <= cfg_data;
          ptc_pkg::REG_PRESS_9: p9_r <= cfg_data[15:0];
          default: p9_r <= p9_r;
        endcase
      end
    end
    if (in_valid && in_ready) begin
      kind_r <= in_data.kind;
      raw_r  <= in_data.raw_value;
    end
    sq_r       <= sq_nxt;
    v2_r       <= v2_nxt;
    x_r        <= x_nxt;
    den_r      <= den_nxt;
    q_r        <= q_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    rt_r       <= rt_nxt;
    rp_r       <= rp_nxt;
    dz_r       <= dz_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_dz_only_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.result_kind == ptc_pkg::KIND_PRESS)
    else $error("divide flag on a temperature word");

  a_temp_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == ptc_pkg::KIND_TEMP |-> out_data.pressure_q24_8 == 32'd0)
    else $error("pressure field set on a temperature word");

endmodule
